@@ rtl/bfl_pkg.sv @@
// Shared types, constants and the range weight table for the 3x3 Lab bilateral filter.
// No dependencies; imported by every module of the block.
package bfl_pkg;

  localparam int RANGE_TABLE_DEPTH = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W = $clog2(RANGE_TABLE_DEPTH);
  localparam int NUM_PIX = 9;
  localparam int CENTER_PIX = 4;
  localparam int PIX_W = 24;
  localparam int CH_W = 8;
  localparam int D2_W = 18;
  localparam int DIST_LIMIT = 4096;
  localparam int DIST_SHIFT = 12;
  localparam int W_W = 2 * WEIGHT_BITS;
  localparam int PROD_W = W_W + CH_W;
  localparam int NUM_W = PROD_W + 4;
  localparam int DEN_W = W_W + 4;
  localparam int QUO_W = CH_W;
  // Pipeline: four lane stages, two adder stages, one stage per quotient bit.
  localparam int LANE_STG = 4;
  localparam int SUM_STG = 2;
  localparam int NSTG = LANE_STG + SUM_STG + QUO_W;
  localparam int DIV_FIRST = LANE_STG + SUM_STG + 1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_EDGE = 2'd1;
  localparam logic [1:0] REG_CORNER = 2'd2;

  localparam logic [95:0] EXP_STEP_Q32 = 96'd4280080078;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WEIGHT_BITS-1:0] wgt_t;
  typedef logic [NSTG:1] stage_en_t;
  typedef logic [RANGE_TABLE_DEPTH-1:0][WEIGHT_BITS-1:0] range_rom_t;

  // Entry k holds exp(-d/288) for d = k*4096/depth, built by repeated
  // Q0.32 multiplication and rounded to the weight width.
  function automatic range_rom_t build_range_rom();
    range_rom_t rom;
    logic [95:0] v;
    logic [95:0] w;
    logic [95:0] maxw;
    int unsigned d;
    int unsigned target;
    v = 96'd1 << 32;
    d = 0;
    maxw = (96'd1 << WEIGHT_BITS) - 96'd1;
    for (int k = 0; k < RANGE_TABLE_DEPTH; k++) begin
      target = (k * DIST_LIMIT) / RANGE_TABLE_DEPTH;
      while (d < target) begin
        v = (v * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
        d++;
      end
      w = (v + (96'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
      if (w > maxw) begin
        w = maxw;
      end
      rom[k] = w[WEIGHT_BITS-1:0];
    end
    return rom;
  endfunction

  localparam range_rom_t RANGE_ROM = build_range_rom();

  function automatic logic [CH_W-1:0] chan(input pix_t px, input int c);
    return px[PIX_W-1-CH_W*c -: CH_W];
  endfunction

endpackage

@@ rtl/bilateral_filter_3x3_lab_top.sv @@
// Top level of the 3x3 Lab bilateral filter: stream ports, APB register file,
// pipeline flow control. Depends on bfl_pkg, bfl_lane and bfl_merge.
//
// The filter accepts one 3x3 window per clock and runs it through a 14-stage
// pipeline: nine parallel lanes spend four stages on distance, range table
// lookup and weighting, two stages add the lanes together, and a per-channel
// restoring divider produces one quotient bit per stage over eight stages.
// Every stage holds its item under backpressure and bubbles close up,
// so the sustained rate is one item per cycle whenever the output is taken.
// The three spatial weights must be written over APB only while no item is in
// flight; the block itself does not enforce this.
module bilateral_filter_3x3_lab_top
  import bfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // win_up_left, win_up, win_up_right, win_left, win_center, win_right,
  // win_down_left, win_down, win_down_right (24 bits each, lowest first)
  input  logic [9*PIX_W-1:0]   s_tdata,
  input  logic                 s_tuser,   // border_pass
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic [3*CH_W-1:0]    m_tdata,   // filt_l [7:0], filt_a [15:8], filt_b [23:16]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  wgt_t weight_center, weight_edge, weight_corner;
  logic [NSTG:1] vld;
  stage_en_t en;
  logic [1:0] reg_idx;
  logic [NUM_PIX-1:0][W_W-1:0] wt;
  logic [NUM_PIX-1:0][2:0][PROD_W-1:0] prod;
  pix_t px_out [NUM_PIX];
  logic [LANE_STG:1] bord;

  // Register file.
  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_center <= 16'd65535;
      weight_edge <= 16'd65407;
      weight_corner <= 16'd65280;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER: weight_center <= pwdata[WEIGHT_BITS-1:0];
        REG_EDGE:   weight_edge <= pwdata[WEIGHT_BITS-1:0];
        REG_CORNER: weight_corner <= pwdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER: prdata = 32'(weight_center);
      REG_EDGE:   prdata = 32'(weight_edge);
      REG_CORNER: prdata = 32'(weight_corner);
      default:    prdata = '0;
    endcase
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[NSTG] = !vld[NSTG] || m_tready;
    for (int s = NSTG - 1; s >= 1; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int s = 2; s <= NSTG; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NSTG];

  // Border flag rides alongside the lane stages.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      bord[1] <= s_tuser;
    end
    for (int s = 2; s <= LANE_STG; s++) begin
      if (en[s]) begin
        bord[s] <= bord[s-1];
      end
    end
  end

  // Nine lanes, one per window position.
  for (genvar i = 0; i < NUM_PIX; i++) begin : g_lane
    wgt_t sw;
    if (i == CENTER_PIX) begin : g_c
      assign sw = weight_center;
    end else if (i == 1 || i == 3 || i == 5 || i == 7) begin : g_e
      assign sw = weight_edge;
    end else begin : g_k
      assign sw = weight_corner;
    end

    bfl_lane u_lane (
      .clk    (clk),
      .en     (en),
      .px     (s_tdata[PIX_W*i +: PIX_W]),
      .ctr    (s_tdata[PIX_W*CENTER_PIX +: PIX_W]),
      .sw     (sw),
      .wt     (wt[i]),
      .prod   (prod[i]),
      .px_out (px_out[i])
    );
  end

  bfl_merge u_merge (
    .clk    (clk),
    .en     (en),
    .wt     (wt),
    .prod   (prod),
    .ctr    (px_out[CENTER_PIX]),
    .border (bord[LANE_STG]),
    .result (m_tdata)
  );

endmodule

@@ rtl/bfl_lane.sv @@
// One pixel lane: color distance, range weight lookup, total weight and the
// weighted channels. Depends on bfl_pkg.
module bfl_lane
  import bfl_pkg::*;
(
  input  logic                     clk,
  input  stage_en_t                en,
  input  pix_t                     px,
  input  pix_t                     ctr,
  input  wgt_t                     sw,
  output logic [W_W-1:0]           wt,
  output logic [2:0][PROD_W-1:0]   prod,
  output pix_t                     px_out
);

  logic [D2_W-1:0] d2;
  logic [IDX_W-1:0] idx;
  logic far;
  pix_t px1, px2, px3;
  wgt_t rw;
  logic [W_W-1:0] w3;
  logic [IDX_W+DIST_SHIFT-1:0] idx_prod;

  // Squared Lab distance to the center pixel.
  always_comb begin
    logic [CH_W-1:0] pa;
    logic [CH_W-1:0] pb;
    logic [CH_W-1:0] ad;
    logic [2*CH_W-1:0] sq;
    d2 = '0;
    for (int c = 0; c < 3; c++) begin
      pa = chan(px, c);
      pb = chan(ctr, c);
      ad = (pa >= pb) ? pa - pb : pb - pa;
      sq = (2*CH_W)'(ad) * (2*CH_W)'(ad);
      d2 = d2 + D2_W'(sq);
    end
  end

  assign idx_prod = (IDX_W+DIST_SHIFT)'(d2[DIST_SHIFT-1:0]) *
                    (IDX_W+DIST_SHIFT)'(RANGE_TABLE_DEPTH);

  // Stage 1: table index and far-color flag.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      far <= (d2 >= D2_W'(DIST_LIMIT));
      idx <= idx_prod[IDX_W+DIST_SHIFT-1:DIST_SHIFT];
      px1 <= px;
    end
  end

  // Stage 2: range weight from the table.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rw <= far ? '0 : RANGE_ROM[idx];
      px2 <= px1;
    end
  end

  // Stage 3: range weight times spatial weight.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      w3 <= W_W'(rw) * W_W'(sw);
      px3 <= px2;
    end
  end

  // Stage 4: weighted channel values.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      wt <= w3;
      px_out <= px3;
      for (int c = 0; c < 3; c++) begin
        prod[c] <= PROD_W'(w3) * PROD_W'(chan(px3, c));
      end
    end
  end

endmodule

@@ rtl/bfl_merge.sv @@
// Merging stage: adder tree over the nine lanes, then an 8-stage restoring
// divider per channel and the border/zero-weight bypass. Depends on bfl_pkg.
module bfl_merge
  import bfl_pkg::*;
(
  input  logic                                clk,
  input  stage_en_t                           en,
  input  logic [NUM_PIX-1:0][W_W-1:0]         wt,
  input  logic [NUM_PIX-1:0][2:0][PROD_W-1:0] prod,
  input  pix_t                                ctr,
  input  logic                                border,
  output logic [3*CH_W-1:0]                   result
);

  logic [2:0][DEN_W-1:0] den5;
  logic [2:0][2:0][NUM_W-1:0] num5;
  pix_t ctr5;
  logic bord5;

  logic [DEN_W-1:0] den6;
  logic [2:0][NUM_W-1:0] num6;
  pix_t ctr6;
  logic bord6;

  logic [DIV_FIRST:NSTG-1][DEN_W-1:0] dd;
  logic [DIV_FIRST:NSTG-1][2:0][NUM_W-1:0] rem;
  logic [DIV_FIRST:NSTG-1][2:0][QUO_W-1:0] quo;
  logic [DIV_FIRST:NSTG-1] pass;
  pix_t ctrd [DIV_FIRST:NSTG-1];

  // Stage 5: partial sums over groups of three lanes.
  always_ff @(posedge clk) begin
    if (en[LANE_STG+1]) begin
      ctr5 <= ctr;
      bord5 <= border;
      for (int g = 0; g < 3; g++) begin
        den5[g] <= DEN_W'(wt[3*g]) + DEN_W'(wt[3*g+1]) + DEN_W'(wt[3*g+2]);
        for (int c = 0; c < 3; c++) begin
          num5[g][c] <= NUM_W'(prod[3*g][c]) + NUM_W'(prod[3*g+1][c]) +
                        NUM_W'(prod[3*g+2][c]);
        end
      end
    end
  end

  // Stage 6: totals.
  always_ff @(posedge clk) begin
    if (en[LANE_STG+2]) begin
      ctr6 <= ctr5;
      bord6 <= bord5;
      den6 <= den5[0] + den5[1] + den5[2];
      for (int c = 0; c < 3; c++) begin
        num6[c] <= num5[0][c] + num5[1][c] + num5[2][c];
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = DIV_FIRST; s <= NSTG; s++) begin : g_div
    localparam int B = NSTG - s;
    logic [DEN_W-1:0] d_in;
    logic [2:0][NUM_W-1:0] r_in;
    logic [2:0][QUO_W-1:0] q_in;
    logic p_in;
    pix_t c_in;
    logic [2:0][NUM_W-1:0] r_out;
    logic [2:0][QUO_W-1:0] q_out;
    logic [NUM_W-1:0] dsh;

    if (s == DIV_FIRST) begin : g_src0
      assign d_in = den6;
      assign r_in = num6;
      assign q_in = '0;
      assign p_in = bord6 | (den6 == '0);
      assign c_in = ctr6;
    end else begin : g_srcn
      assign d_in = dd[s-1];
      assign r_in = rem[s-1];
      assign q_in = quo[s-1];
      assign p_in = pass[s-1];
      assign c_in = ctrd[s-1];
    end

    assign dsh = NUM_W'(d_in) << B;

    always_comb begin
      r_out = r_in;
      q_out = q_in;
      for (int c = 0; c < 3; c++) begin
        if (r_in[c] >= dsh) begin
          r_out[c] = r_in[c] - dsh;
          q_out[c][B] = 1'b1;
        end
      end
    end

    if (s < NSTG) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[s]) begin
          dd[s] <= d_in;
          rem[s] <= r_out;
          quo[s] <= q_out;
          pass[s] <= p_in;
          ctrd[s] <= c_in;
        end
      end
    end else begin : g_last
      // Output register, packed filt_l low, filt_b high.
      always_ff @(posedge clk) begin
        if (en[s]) begin
          if (p_in) begin
            result <= {chan(c_in, 2), chan(c_in, 1), chan(c_in, 0)};
          end else begin
            result <= {q_out[2], q_out[1], q_out[0]};
          end
        end
      end
    end
  end

endmodule

@@ rtl/bfl_checker.sv @@
// Port-level checks for the 3x3 Lab bilateral filter, bound to the top level.
// Depends on bfl_pkg for the data widths.
module bfl_checker
  import bfl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic [3*CH_W-1:0]   m_tdata,
  input logic                m_tvalid,
  input logic                m_tready
);

  // An empty output stage lets the whole pipeline advance.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output");

  // A taken output never blocks the input.
  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready) else $error("input stalled while output drains");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result shown right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind bilateral_filter_3x3_lab_top bfl_checker u_bfl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
